/* sv/serial_line_edit_buffer_defines.svh */
// Assertion macros used by the line edit buffer sequencer RTL.
`ifndef SERIAL_LINE_EDIT_BUFFER_DEFINES_SVH
`define SERIAL_LINE_EDIT_BUFFER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define SLE_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define SLE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/sle_pkg.sv */
// Package: result type, character codes, sequencer states and key classifier.
`default_nettype none

package sle_pkg;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_USCR  = 8'h5F;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LF,
      S_LEN,
      S_STREAM
   } state_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       line_found;
      logic       last;
      logic       erase_echo;
      logic       dropped;
   } rsp_type;

   function automatic logic is_text_key(input logic [7:0] c);
      logic res;
      res = ((c >= 8'h61) && (c <= 8'h7A)) ||
            ((c >= 8'h41) && (c <= 8'h5A)) ||
            ((c >= 8'h30) && (c <= 8'h39)) ||
            (c == CHAR_SPACE) || (c == CHAR_DOT) ||
            (c == CHAR_USCR) || (c == CHAR_DASH);
      return res;
   endfunction

endpackage

`default_nettype wire

/* sv/sle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/sle_out.sv */
// Result output register: holds one result until its transfer.
`default_nettype none

module sle_out (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire sle_pkg::rsp_type data,
   output logic                 free,
   input  wire logic            rsp_ready,
   output logic                 rsp_valid,
   output logic      [7:0]      rsp_out_char,
   output logic                 rsp_char_valid,
   output logic                 rsp_line_found,
   output logic                 rsp_last,
   output logic                 rsp_erase_echo,
   output logic                 rsp_dropped
);

   import sle_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_char   = data_ff.out_char;
   assign rsp_char_valid = data_ff.char_valid;
   assign rsp_line_found = data_ff.line_found;
   assign rsp_last       = data_ff.last;
   assign rsp_erase_echo = data_ff.erase_echo;
   assign rsp_dropped    = data_ff.dropped;

endmodule

`default_nettype wire

/* sv/sle_ctrl.sv */
// Line editor sequencer: ring pointers, open line length and memory access control.
`default_nettype none
`include "serial_line_edit_buffer_defines.svh"

module sle_ctrl #(
   parameter int LINE_BYTES = 64,
   parameter int LINE_SLOTS = 4,
   parameter int SLOT_W     = $clog2(LINE_SLOTS),
   parameter int IDX_W      = $clog2(LINE_BYTES)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_opcode,
   input  wire logic [7:0]               req_key_char,
   input  wire logic                     out_free,
   output logic                          rsp_load,
   output sle_pkg::rsp_type              rsp_data,
   output logic                          st_we,
   output logic      [SLOT_W+IDX_W-1:0]  st_waddr,
   output logic      [7:0]               st_wdata,
   output logic                          st_re,
   output logic      [SLOT_W+IDX_W-1:0]  st_raddr,
   input  wire logic [7:0]               st_rdata,
   output logic                          len_we,
   output logic      [SLOT_W-1:0]        len_waddr,
   output logic      [IDX_W-1:0]         len_wdata,
   output logic                          len_re,
   output logic      [SLOT_W-1:0]        len_raddr,
   input  wire logic [IDX_W-1:0]         len_rdata
);

   import sle_pkg::*;

   localparam int CNT_W = $clog2(LINE_SLOTS + 1);
   localparam logic [IDX_W-1:0]  MAX_TEXT  = IDX_W'(LINE_BYTES - 2);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(LINE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LINE_SLOTS - 1);

   state_type                   state_ff, state_in;
   logic [SLOT_W-1:0]           head_ff, head_in;
   logic [SLOT_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            head_len_ff, head_len_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            text_len_ff, text_len_in;
   logic [SLOT_W+IDX_W-1:0]     lf_addr_ff, lf_addr_in;

   logic req_fire;
   logic full;
   logic empty;
   logic key_text;
   logic key_lf;
   logic key_bs;
   logic stream_last;
   logic [SLOT_W-1:0] head_next;
   logic [SLOT_W-1:0] tail_next;

   assign req_ready   = (state_ff == S_IDLE) && out_free;
   assign req_fire    = req_valid && req_ready;
   assign full        = (count_ff == FULL_CNT);
   assign empty       = (count_ff == '0);
   assign key_text    = is_text_key(req_key_char);
   assign key_lf      = (req_key_char == CHAR_LF);
   assign key_bs      = (req_key_char == CHAR_BS);
   assign stream_last = ((idx_ff + 1'b1) == text_len_ff);
   assign head_next   = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_next   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_opcode && !empty) begin
                  state_in = S_LEN;
               end else if (!req_opcode && key_lf && !full) begin
                  state_in = S_LF;
               end
            end
         end
         S_LF: begin
            state_in = S_IDLE;
         end
         S_LEN: begin
            if (len_rdata != '0) begin
               state_in = S_STREAM;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_STREAM: begin
            if (out_free && stream_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      head_len_in = head_len_ff;
      idx_in      = idx_ff;
      text_len_in = text_len_ff;
      lf_addr_in  = lf_addr_ff;
      rsp_load    = 1'b0;
      rsp_data    = '0;
      st_we       = 1'b0;
      st_waddr    = {head_ff, head_len_ff};
      st_wdata    = req_key_char;
      st_re       = 1'b0;
      st_raddr    = {tail_ff, idx_ff};
      len_we      = 1'b0;
      len_waddr   = head_ff;
      len_wdata   = head_len_ff;
      len_re      = 1'b0;
      len_raddr   = tail_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_load      = 1'b1;
               rsp_data.last = 1'b1;
               if (req_opcode) begin
                  if (!empty) begin
                     rsp_load = 1'b0;
                     len_re   = 1'b1;
                  end
               end else if (key_text) begin
                  if (full || (head_len_ff >= MAX_TEXT)) begin
                     rsp_data.dropped = 1'b1;
                  end else begin
                     st_we       = 1'b1;
                     head_len_in = head_len_ff + 1'b1;
                  end
               end else if (key_lf) begin
                  if (full) begin
                     rsp_data.dropped = 1'b1;
                  end else begin
                     // CR now, LF in the following cycle
                     st_we       = 1'b1;
                     st_wdata    = CHAR_CR;
                     len_we      = 1'b1;
                     lf_addr_in  = {head_ff, head_len_ff + 1'b1};
                     count_in    = count_ff + 1'b1;
                     head_in     = head_next;
                     head_len_in = '0;
                  end
               end else if (key_bs) begin
                  if (!full && (head_len_ff != '0)) begin
                     head_len_in         = head_len_ff - 1'b1;
                     rsp_data.erase_echo = 1'b1;
                  end
               end
            end
         end
         S_LF: begin
            st_we    = 1'b1;
            st_waddr = lf_addr_ff;
            st_wdata = CHAR_LF;
         end
         S_LEN: begin
            if (len_rdata == '0) begin
               if (out_free) begin
                  rsp_load            = 1'b1;
                  rsp_data.line_found = 1'b1;
                  rsp_data.last       = 1'b1;
                  tail_in             = tail_next;
                  count_in            = count_ff - 1'b1;
                  if (full) begin
                     head_len_in = '0;
                  end
               end
            end else begin
               text_len_in = len_rdata;
               idx_in      = '0;
               st_re       = 1'b1;
               st_raddr    = {tail_ff, {IDX_W{1'b0}}};
            end
         end
         S_STREAM: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_data.out_char   = st_rdata;
               rsp_data.char_valid = 1'b1;
               rsp_data.line_found = 1'b1;
               rsp_data.last       = stream_last;
               if (stream_last) begin
                  tail_in  = tail_next;
                  count_in = count_ff - 1'b1;
                  // a full ring's open slot is the one just freed
                  if (full) begin
                     head_len_in = '0;
                  end
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  st_re    = 1'b1;
                  st_raddr = {tail_ff, idx_ff + 1'b1};
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         head_len_ff <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         head_len_ff <= head_len_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      text_len_ff <= text_len_in;
      lf_addr_ff  <= lf_addr_in;
   end

   `SLE_ASSERT_ALWAYS(a_count_range, count_ff <= FULL_CNT, "line count above slot count")
   `SLE_ASSERT_ALWAYS(a_open_len, head_len_ff <= MAX_TEXT, "open line overruns CRLF room")
   `SLE_ASSERT_IMPLIES(a_full_ptrs, full, head_ff == tail_ff, "full ring with head off tail")
   `SLE_ASSERT_IMPLIES(a_no_wr_stream, state_ff == S_STREAM, !st_we && !len_we,
                       "memory write during line read-out")
   `SLE_ASSERT_NEXT(a_last_idle, rsp_load && rsp_data.last && (state_ff != S_IDLE),
                    state_ff == S_IDLE, "sequencer busy after final line result")

endmodule

`default_nettype wire

/* sv/serial_line_edit_buffer.sv */
// Top level: keystroke line editor over a ring of line slots held in RAM.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_opcode, req_key_char
//  rsp     | out       | rsp_valid / rsp_ready | rsp_out_char .. rsp_dropped
//
// Keystroke: its status result is in the output register the cycle after it is taken;
// a newline that closes a line then holds off the input while S_LF stores LF.
// Pull: S_LEN reads the line length, then one character per cycle, paced by the
// line RAM read port, while the output is free; an empty ring gives one result.
// Reset clears pointers and counts only; no memory clearing pass is needed.
// A stalled output holds its result; the RAM read data waits with it.
`default_nettype none

module serial_line_edit_buffer #(
   parameter int LINE_BYTES = 64,
   parameter int LINE_SLOTS = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_opcode,
   input  wire logic [7:0] req_key_char,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [7:0] rsp_out_char,
   output logic            rsp_char_valid,
   output logic            rsp_line_found,
   output logic            rsp_last,
   output logic            rsp_erase_echo,
   output logic            rsp_dropped
);

   import sle_pkg::*;

   localparam int SLOT_W   = $clog2(LINE_SLOTS);
   localparam int IDX_W    = $clog2(LINE_BYTES);
   localparam int ADDR_W   = SLOT_W + IDX_W;
   localparam int ST_DEPTH = 2 ** ADDR_W;

   logic              out_free;
   logic              rsp_load;
   rsp_type           rsp_data;
   logic              st_we;
   logic [ADDR_W-1:0] st_waddr;
   logic [7:0]        st_wdata;
   logic              st_re;
   logic [ADDR_W-1:0] st_raddr;
   logic [7:0]        st_rdata;
   logic              len_we;
   logic [SLOT_W-1:0] len_waddr;
   logic [IDX_W-1:0]  len_wdata;
   logic              len_re;
   logic [SLOT_W-1:0] len_raddr;
   logic [IDX_W-1:0]  len_rdata;

   sle_ram #(
      .WIDTH (8),
      .DEPTH (ST_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   // text length of each closed line
   sle_ram #(
      .WIDTH (IDX_W),
      .DEPTH (LINE_SLOTS)
   ) u_line_len (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_en   (len_re),
      .rd_addr (len_raddr),
      .rd_data (len_rdata)
   );

   sle_ctrl #(
      .LINE_BYTES (LINE_BYTES),
      .LINE_SLOTS (LINE_SLOTS),
      .SLOT_W     (SLOT_W),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_key_char (req_key_char),
      .out_free     (out_free),
      .rsp_load     (rsp_load),
      .rsp_data     (rsp_data),
      .st_we        (st_we),
      .st_waddr     (st_waddr),
      .st_wdata     (st_wdata),
      .st_re        (st_re),
      .st_raddr     (st_raddr),
      .st_rdata     (st_rdata),
      .len_we       (len_we),
      .len_waddr    (len_waddr),
      .len_wdata    (len_wdata),
      .len_re       (len_re),
      .len_raddr    (len_raddr),
      .len_rdata    (len_rdata)
   );

   sle_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (rsp_load),
      .data           (rsp_data),
      .free           (out_free),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_line_found (rsp_line_found),
      .rsp_last       (rsp_last),
      .rsp_erase_echo (rsp_erase_echo),
      .rsp_dropped    (rsp_dropped)
   );

endmodule

`default_nettype wire
